>>> hdl/hse_pkg.sv
// Shared types, constants and round functions of the HMAC-SHA256 engine.
package hse_pkg;

    typedef logic [31:0] word_t;
    typedef logic [0:7][31:0] chain_t;
    typedef logic [0:15][31:0] block_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_ADD
    } core_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FEED,
        ST_FEED_WAIT,
        ST_FIN_CHECK,
        ST_FIN_WAIT0,
        ST_FIN_PAD,
        ST_FIN_SPILL,
        ST_FIN_WAIT1,
        ST_FIN_LEN,
        ST_FIN_WAIT2,
        ST_KEY_PAD,
        ST_KEY_WAIT,
        ST_OUTER,
        ST_OUTER_WAIT,
        ST_INNER,
        ST_INNER_WAIT
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic use_iv;
        logic clear_iv;
    } core_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    localparam logic PHASE_KEY = 1'b0;
    localparam logic PHASE_MSG = 1'b1;
    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [6:0] PAD_LIMIT = 7'd56;
    localparam logic [3:0] MAX_BYTES = 4'd8;
    localparam word_t IPAD_WORD = 32'h36363636;
    localparam word_t OPAD_WORD = 32'h5c5c5c5c;
    localparam word_t PAD_WORD = 32'h80000000;
    localparam word_t OUTER_BITS = 32'd768;

    localparam chain_t SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // Clears every word at or past the first word that holds no byte and below word index limit.
    function automatic block_t mask_block(block_t blk, logic [6:0] fill, logic [4:0] limit);
        logic [7:0] used;
        block_t res;
        used = ({1'b0, fill} + 8'd3) >> 2;
        res = blk;
        for (int i = 0; i < 16; i++) begin
            if ((8'(i) >= used) && (5'(i) < limit)) begin
                res[i] = '0;
            end
        end
        return res;
    endfunction

endpackage

>>> hdl/hse_if.sv
// Valid/ready channel interfaces for input beats and digest beats.
interface hse_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;

    modport source (output valid, func, data_word, byte_count, last, input ready);
    modport sink (input valid, func, data_word, byte_count, last, output ready);
endinterface

interface hse_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word_0;
    logic [63:0] digest_word_1;
    logic [63:0] digest_word_2;
    logic [63:0] digest_word_3;

    modport source (output valid, digest_word_0, digest_word_1, digest_word_2,
                    digest_word_3, input ready);
    modport sink (input valid, digest_word_0, digest_word_1, digest_word_2,
                  digest_word_3, output ready);
endinterface

>>> hdl/hse_core.sv
// SHA-256 compression unit: one round per cycle with a rolling message schedule.
module hse_core (
    input  logic               clk,
    input  logic               rst_n,
    input  hse_pkg::core_cmd_t cmd,
    input  hse_pkg::block_t    block,
    output hse_pkg::core_stat_t stat,
    output hse_pkg::chain_t    chain
);
    import hse_pkg::*;

    core_state_t state_reg, state_next;
    chain_t chain_reg, chain_next;
    chain_t work_reg, work_next;
    block_t sched_reg, sched_next;
    logic [5:0] round_reg, round_next;

    word_t t1;
    word_t t2;
    word_t w_new;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CORE_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = CORE_ROUND;
                end
            end
            CORE_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = CORE_ADD;
                end
            end
            CORE_ADD:
            begin
                state_next = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        t1 = work_reg[7] + big_sigma1(work_reg[4])
           + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
           + ROUND_K[round_reg] + sched_reg[0];
        t2 = big_sigma0(work_reg[0])
           + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
           ^ (work_reg[1] & work_reg[2]));
        w_new = sched_reg[0] + small_sigma0(sched_reg[1]) + sched_reg[9]
              + small_sigma1(sched_reg[14]);
        chain_next = chain_reg;
        work_next = work_reg;
        sched_next = sched_reg;
        round_next = round_reg;
        stat = '0;
        unique case (state_reg)
            CORE_IDLE:
            begin
                if (cmd.start)
                begin
                    if (cmd.use_iv)
                    begin
                        chain_next = SHA_IV;
                        work_next = SHA_IV;
                    end
                    else
                    begin
                        work_next = chain_reg;
                    end
                    sched_next = block;
                    round_next = '0;
                end
                else if (cmd.clear_iv)
                begin
                    chain_next = SHA_IV;
                end
            end
            CORE_ROUND:
            begin
                stat.busy = 1'b1;
                work_next = {t1 + t2, work_reg[0], work_reg[1], work_reg[2],
                             work_reg[3] + t1, work_reg[4], work_reg[5], work_reg[6]};
                sched_next = {sched_reg[1:15], w_new};
                round_next = round_reg + 6'd1;
            end
            CORE_ADD:
            begin
                stat.busy = 1'b1;
                stat.done = 1'b1;
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            chain_reg <= SHA_IV;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        sched_reg <= sched_next;
    end

    assign chain = chain_reg;

endmodule

>>> hdl/hmac_sha256_engine.sv
// Top level of the HMAC-SHA256 engine: byte loader, padding sequencer and digest register.
// Usage: din carries beats of up to eight bytes (first byte in bits 63..56). A job sends
// the key first (func 0) ending with last, then the message (func 1) ending with last.
// Beats of the wrong kind for the current phase are dropped. Byte counts above eight
// count as eight; a count of zero adds nothing but its last mark still acts.
// dout delivers one 256-bit digest per job as four big-endian 64-bit words.
// Flow: a beat is loaded byte by byte, and each full 64-byte block goes through the
// compression unit as a start, 64 rounds at one per cycle, then the chaining add. The
// key end runs the ipad block for a short key, with one or two more blocks first for
// a long key. The message end runs the length, outer-key and final blocks, with a
// padding block first when the padding spills and a full block first when one is pending.
// din.ready is high only while the loader is idle and the job is not being cleared.
// A finished digest waits in the output register; the next job's beats are taken
// meanwhile, but the last block of a second digest waits until the first has been taken.
// Reset clears the job: the engine then expects a new key. After each digest the engine
// also returns to the key phase.
module hmac_sha256_engine (
    input logic       clk,
    input logic       rst_n,
    hse_in_if.sink    din,
    hse_out_if.source dout
);
    import hse_pkg::*;

    seq_state_t state_reg, state_next;
    logic phase_reg, phase_next;
    logic key_hashed_reg, key_hashed_next;
    logic [6:0] fill_reg, fill_next;
    logic [63:0] total_reg, total_next;
    logic [63:0] word_reg, word_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [3:0] idx_reg, idx_next;
    logic func_reg, func_next;
    logic last_reg, last_next;
    block_t buf_reg, buf_next;
    block_t opad_reg, opad_next;
    logic out_valid_reg, out_valid_next;
    chain_t out_reg, out_next;

    core_cmd_t cmd;
    core_stat_t stat;
    chain_t chain;
    block_t core_block;
    block_t key_blk;
    logic emit_ok;
    logic [7:0] put_val;
    logic put_en;

    hse_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .block (core_block),
        .stat  (stat),
        .chain (chain)
    );

    assign din.ready = (state_reg == ST_IDLE)
                     && !((phase_reg == PHASE_MSG) && (total_reg == '0));
    assign emit_ok = !out_valid_reg || dout.ready;
    assign key_blk = key_hashed_reg ? {chain, 256'd0} : mask_block(buf_reg, fill_reg, 5'd16);
    assign core_block = (state_reg == ST_OUTER) ? opad_reg : buf_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (din.valid && din.ready && (din.func == phase_reg))
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (!last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if ((func_reg == PHASE_KEY) && !key_hashed_reg)
                    begin
                        state_next = ST_KEY_PAD;
                    end
                    else
                    begin
                        state_next = ST_FIN_CHECK;
                    end
                end
                else if (fill_reg == BLOCK_BYTES)
                begin
                    state_next = ST_FEED_WAIT;
                end
            end
            ST_FEED_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FIN_CHECK:
            begin
                state_next = (fill_reg == BLOCK_BYTES) ? ST_FIN_WAIT0 : ST_FIN_PAD;
            end
            ST_FIN_WAIT0:
            begin
                if (stat.done)
                begin
                    state_next = ST_FIN_PAD;
                end
            end
            ST_FIN_PAD:
            begin
                state_next = ST_FIN_SPILL;
            end
            ST_FIN_SPILL:
            begin
                state_next = (fill_reg > PAD_LIMIT) ? ST_FIN_WAIT1 : ST_FIN_LEN;
            end
            ST_FIN_WAIT1:
            begin
                if (stat.done)
                begin
                    state_next = ST_FIN_LEN;
                end
            end
            ST_FIN_LEN:
            begin
                state_next = ST_FIN_WAIT2;
            end
            ST_FIN_WAIT2:
            begin
                if (stat.done)
                begin
                    state_next = (phase_reg == PHASE_KEY) ? ST_KEY_PAD : ST_OUTER;
                end
            end
            ST_KEY_PAD:
            begin
                state_next = ST_KEY_WAIT;
            end
            ST_KEY_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUTER:
            begin
                state_next = ST_OUTER_WAIT;
            end
            ST_OUTER_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = ST_INNER;
                end
            end
            ST_INNER:
            begin
                if (emit_ok)
                begin
                    state_next = ST_INNER_WAIT;
                end
            end
            ST_INNER_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        key_hashed_next = key_hashed_reg;
        fill_next = fill_reg;
        total_next = total_reg;
        word_next = word_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        func_next = func_reg;
        last_next = last_reg;
        buf_next = buf_reg;
        opad_next = opad_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        cmd = '0;
        put_en = 1'b0;
        put_val = word_reg[63:56];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    word_next = din.data_word;
                    cnt_next = (din.byte_count > MAX_BYTES) ? MAX_BYTES : din.byte_count;
                    func_next = din.func;
                    last_next = din.last;
                    idx_next = '0;
                end
            end
            ST_FEED:
            begin
                if (idx_reg != cnt_reg)
                begin
                    if (fill_reg == BLOCK_BYTES)
                    begin
                        cmd.start = 1'b1;
                    end
                    else
                    begin
                        put_en = 1'b1;
                        word_next = {word_reg[55:0], 8'd0};
                        idx_next = idx_reg + 4'd1;
                        total_next = total_reg + 64'd1;
                    end
                end
            end
            ST_FEED_WAIT:
            begin
                if (stat.done)
                begin
                    fill_next = '0;
                    if (phase_reg == PHASE_KEY)
                    begin
                        key_hashed_next = 1'b1;
                    end
                end
            end
            ST_FIN_CHECK:
            begin
                if (fill_reg == BLOCK_BYTES)
                begin
                    cmd.start = 1'b1;
                end
            end
            ST_FIN_WAIT0, ST_FIN_WAIT1:
            begin
                if (stat.done)
                begin
                    fill_next = '0;
                end
            end
            ST_FIN_PAD:
            begin
                put_en = 1'b1;
                put_val = 8'h80;
            end
            ST_FIN_SPILL:
            begin
                if (fill_reg > PAD_LIMIT)
                begin
                    buf_next = mask_block(buf_reg, fill_reg, 5'd16);
                    cmd.start = 1'b1;
                end
            end
            ST_FIN_LEN:
            begin
                buf_next = mask_block(buf_reg, fill_reg, 5'd14);
                buf_next[14] = total_reg[60:29];
                buf_next[15] = {total_reg[28:0], 3'b000};
                cmd.start = 1'b1;
            end
            ST_FIN_WAIT2:
            begin
                if (stat.done)
                begin
                    fill_next = '0;
                end
            end
            ST_KEY_PAD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    opad_next[i] = key_blk[i] ^ OPAD_WORD;
                    buf_next[i] = key_blk[i] ^ IPAD_WORD;
                end
                cmd.start = 1'b1;
                cmd.use_iv = 1'b1;
            end
            ST_KEY_WAIT:
            begin
                if (stat.done)
                begin
                    total_next = 64'd64;
                    fill_next = '0;
                    key_hashed_next = 1'b0;
                    phase_next = PHASE_MSG;
                end
            end
            ST_OUTER:
            begin
                buf_next = {chain, PAD_WORD, 192'd0, OUTER_BITS};
                cmd.start = 1'b1;
                cmd.use_iv = 1'b1;
            end
            ST_OUTER_WAIT:
            begin
            end
            ST_INNER:
            begin
                cmd.start = emit_ok;
            end
            ST_INNER_WAIT:
            begin
            end
            default:
            begin
            end
        endcase
        // The chaining value only settles at the done edge, so the digest is captured and
        // the job cleared in the following cycle, once the sequencer is back at idle.
        if ((state_reg == ST_IDLE) && (phase_reg == PHASE_MSG) && (total_reg == '0))
        begin
            cmd.clear_iv = 1'b1;
            phase_next = PHASE_KEY;
            out_next = chain;
            out_valid_next = 1'b1;
        end
        if ((state_reg == ST_INNER_WAIT) && stat.done)
        begin
            fill_next = '0;
            total_next = '0;
            key_hashed_next = 1'b0;
        end
        if (put_en)
        begin
            unique case (fill_reg[1:0])
                2'd0: buf_next[fill_reg[5:2]] = {put_val, 24'd0};
                2'd1: buf_next[fill_reg[5:2]] = buf_reg[fill_reg[5:2]] | {8'd0, put_val, 16'd0};
                2'd2: buf_next[fill_reg[5:2]] = buf_reg[fill_reg[5:2]] | {16'd0, put_val, 8'd0};
                2'd3: buf_next[fill_reg[5:2]] = buf_reg[fill_reg[5:2]] | {24'd0, put_val};
                default: buf_next[fill_reg[5:2]] = buf_reg[fill_reg[5:2]];
            endcase
            fill_next = fill_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PHASE_KEY;
            key_hashed_reg <= 1'b0;
            fill_reg <= '0;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            key_hashed_reg <= key_hashed_next;
            fill_reg <= fill_next;
            total_reg <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        func_reg <= func_next;
        last_reg <= last_next;
        buf_reg <= buf_next;
        opad_reg <= opad_next;
        out_reg <= out_next;
    end

    assign dout.valid = out_valid_reg;
    assign dout.digest_word_0 = {out_reg[0], out_reg[1]};
    assign dout.digest_word_1 = {out_reg[2], out_reg[3]};
    assign dout.digest_word_2 = {out_reg[4], out_reg[5]};
    assign dout.digest_word_3 = {out_reg[6], out_reg[7]};

endmodule

>>> test/tb_hmac_sha256_engine.sv
// Self-checking testbench for the HMAC-SHA256 engine: random jobs checked against a local HMAC model.
`timescale 1ns / 1ps

module tb_hmac_sha256_engine;
    import hse_pkg::*;

    typedef struct {
        logic        func;
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last;
    } beat_t;

    typedef struct {
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
    } digest_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   accepted_in;
    int   digests_seen;
    int   idle_cycles;
    bit   hold_out;
    bit   stim_done;

    hse_in_if  din ();
    hse_out_if dout ();

    hmac_sha256_engine uut (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (din.sink),
        .dout (dout.source)
    );

    function automatic logic [31:0] rotr32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    class hmac_scoreboard;
        logic [31:0] chain[8];
        logic [31:0] blk[16];
        logic [63:0] opad[8];
        int          fill;
        logic [63:0] total;
        bit          key_long;
        logic        phase;
        digest_t     pending[$];

        function new();
            clear_job();
        endfunction

        function void clear_job();
            for (int i = 0; i < 8; i++) chain[i] = SHA_IV[i];
            fill = 0;
            total = '0;
            key_long = 0;
            phase = PHASE_KEY;
        endfunction

        function void compress(logic [31:0] b[16]);
            logic [31:0] w[64];
            logic [31:0] v[8];
            logic [31:0] t1, t2, s0, s1;
            for (int i = 0; i < 16; i++) w[i] = b[i];
            for (int i = 16; i < 64; i++) begin
                s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            v = chain;
            for (int r = 0; r < 64; r++) begin
                t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
                t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] += v[i];
        endfunction

        function void put_byte(logic [7:0] b);
            if (fill % 4 == 0) blk[fill / 4] = {b, 24'd0};
            else blk[fill / 4] |= 32'(b) << ((3 - fill % 4) * 8);
            fill++;
        endfunction

        function void feed_byte(logic [7:0] b);
            if (fill >= 64) begin
                compress(blk);
                fill = 0;
                if (phase == PHASE_KEY) key_long = 1;
            end
            put_byte(b);
            total++;
        endfunction

        function void finish_hash();
            logic [63:0] bits;
            bits = total << 3;
            if (fill >= 64) begin
                compress(blk);
                fill = 0;
            end
            put_byte(8'h80);
            if (fill > 56) begin
                for (int i = (fill + 3) / 4; i < 16; i++) blk[i] = '0;
                compress(blk);
                fill = 0;
            end
            for (int i = (fill + 3) / 4; i < 14; i++) blk[i] = '0;
            blk[14] = bits[63:32];
            blk[15] = bits[31:0];
            compress(blk);
            fill = 0;
        endfunction

        function void note_input(beat_t bt);
            logic [31:0] key[16];
            logic [31:0] pad[16];
            logic [31:0] inner[8];
            int          n;
            digest_t     d;
            n = (bt.byte_count > 8) ? 8 : int'(bt.byte_count);
            if (bt.func != phase) return;
            for (int i = 0; i < n; i++) feed_byte(bt.data_word[63 - 8 * i -: 8]);
            if (!bt.last) return;
            if (bt.func == PHASE_KEY) begin
                for (int i = 0; i < 16; i++) key[i] = '0;
                if (key_long) begin
                    finish_hash();
                    for (int i = 0; i < 8; i++) key[i] = chain[i];
                end else begin
                    for (int i = 0; i < (fill + 3) / 4; i++) key[i] = blk[i];
                end
                for (int i = 0; i < 16; i++) pad[i] = key[i] ^ IPAD_WORD;
                for (int i = 0; i < 8; i++)
                    opad[i] = {key[2*i] ^ OPAD_WORD, key[2*i+1] ^ OPAD_WORD};
                for (int i = 0; i < 8; i++) chain[i] = SHA_IV[i];
                compress(pad);
                total = 64;
                fill = 0;
                key_long = 0;
                phase = PHASE_MSG;
            end else begin
                finish_hash();
                inner = chain;
                for (int i = 0; i < 8; i++) chain[i] = SHA_IV[i];
                for (int i = 0; i < 8; i++) begin
                    pad[2*i] = opad[i][63:32];
                    pad[2*i+1] = opad[i][31:0];
                end
                compress(pad);
                for (int i = 0; i < 16; i++) pad[i] = '0;
                for (int i = 0; i < 8; i++) pad[i] = inner[i];
                pad[8] = PAD_WORD;
                pad[15] = OUTER_BITS;
                compress(pad);
                d.w0 = {chain[0], chain[1]};
                d.w1 = {chain[2], chain[3]};
                d.w2 = {chain[4], chain[5]};
                d.w3 = {chain[6], chain[7]};
                pending.push_back(d);
                clear_job();
            end
        endfunction

        task check_digest(digest_t got);
            digest_t want;
            if (pending.size() == 0) begin
                report_mismatch("digest with none expected");
                return;
            end
            want = pending.pop_front();
            if (got.w0 !== want.w0) report_mismatch("digest_word_0");
            if (got.w1 !== want.w1) report_mismatch("digest_word_1");
            if (got.w2 !== want.w2) report_mismatch("digest_word_2");
            if (got.w3 !== want.w3) report_mismatch("digest_word_3");
        endtask
    endclass

    hmac_scoreboard hmac_sb;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_beat(logic func, logic [63:0] word, logic [3:0] cnt, logic last,
                             bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge clk);
        din.valid      <= 1'b1;
        din.func       <= func;
        din.data_word  <= word;
        din.byte_count <= cnt;
        din.last       <= last;
        do @(posedge clk); while (!din.ready);
        din.valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_stream(logic func, int nbytes, bit no_gap = 0);
        int left;
        int c;
        left = nbytes;
        while (left > 8 || (left > 0 && $urandom_range(0, 5) == 0)) begin
            c = $urandom_range(1, (left > 8) ? 8 : left);
            if (c == left) break;
            send_beat(func, rand64(), 4'(c), 1'b0, no_gap);
            left -= c;
        end
        send_beat(func, rand64(), 4'(left), 1'b1, no_gap);
    endtask

    task automatic wait_drained();
        while (hmac_sb.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n && din.valid && din.ready) begin
            hmac_sb.note_input('{din.func, din.data_word, din.byte_count, din.last});
            accepted_in++;
        end
        if (rst_n && dout.valid && dout.ready) begin
            hmac_sb.check_digest('{dout.digest_word_0, dout.digest_word_1,
                                   dout.digest_word_2, dout.digest_word_3});
            digests_seen++;
        end
    end

    initial begin
        int gap;
        dout.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_out) begin
                dout.ready <= 1'b0;
                repeat (2000) @(posedge clk);
                hold_out = 0;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
            if (gap != 0) begin
                dout.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            dout.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if ((din.valid && din.ready) || (dout.valid && dout.ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int klen;
        int mlen;
        hmac_sb = new();
        mismatches = 0;
        accepted_in = 0;
        digests_seen = 0;
        idle_cycles = 0;
        hold_out = 0;
        stim_done = 0;
        rst_n = 1'b0;
        din.valid = 1'b0;
        din.func = 1'b0;
        din.data_word = '0;
        din.byte_count = '0;
        din.last = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty key, wrong-kind beats, empty message, oversize counts.
        send_beat(PHASE_MSG, '1, 4'd8, 1'b1);
        send_beat(PHASE_KEY, '0, 4'd0, 1'b1);
        send_beat(PHASE_KEY, '1, 4'd8, 1'b1);
        send_beat(PHASE_MSG, '0, 4'd0, 1'b1);
        send_beat(PHASE_KEY, '1, 4'd15, 1'b1);
        send_beat(PHASE_MSG, '1, 4'd9, 1'b0);
        send_beat(PHASE_MSG, 64'h0123456789abcdef, 4'd3, 1'b1);
        // Exactly 64 key bytes, then 65 key bytes (hashed key).
        for (int i = 0; i < 8; i++) send_beat(PHASE_KEY, rand64(), 4'd8, i == 7);
        send_beat(PHASE_MSG, rand64(), 4'd8, 1'b1);
        for (int i = 0; i < 8; i++) send_beat(PHASE_KEY, '1, 4'd8, 1'b0);
        send_beat(PHASE_KEY, '1, 4'd1, 1'b1);
        send_beat(PHASE_MSG, '1, 4'd8, 1'b0);
        send_beat(PHASE_MSG, '0, 4'd0, 1'b1);
        wait_drained();

        hold_out = 1;
        while (accepted_in < 750) begin
            case ($urandom_range(0, 9))
                0: klen = $urandom_range(65, 200);
                1: klen = 64;
                default: klen = $urandom_range(0, 40);
            endcase
            mlen = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(0, 70);
            if ($urandom_range(0, 9) == 0)
                send_beat(1'($urandom_range(0, 1)), rand64(), 4'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)));
            send_stream(PHASE_KEY, klen, hold_out);
            send_stream(PHASE_MSG, mlen, hold_out);
            if ($urandom_range(0, 19) == 0) wait_drained();
        end
        stim_done = 1;
        wait_drained();
        $display("Ran %0d accepted input beats and checked %0d digests,",
                 accepted_in, digests_seen);
        $display("covering empty, 64-byte and hashed keys, dropped beats and output stalls.");
        if (mismatches == 0 && hmac_sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
